@@ hw/rtl/lpkrc_pkg.sv @@
package lpkrc_pkg;

   typedef enum logic [2:0] {
      OP_LOOKUP     = 3'd0,
      OP_UPDATE     = 3'd1,
      OP_REFRESH    = 3'd2,
      OP_INVALIDATE = 3'd3,
      OP_FLUSH      = 3'd4
   } op_type;

   typedef struct packed {
      logic [2:0]         operation;
      logic [63:0]        key;
      logic [31:0]        version;
      logic signed [15:0] root_found;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [15:0] root;
      logic [12:0]        probes;
      logic               flushed;
      logic [12:0]        entry_count;
   } rsp_type;

   localparam int KEY_SHIFT = 3;

   // Number of slots. The home slot takes the low key bits above KEY_SHIFT,
   // so this stays a power of two.
   localparam int CAPACITY = 4096;

endpackage

@@ hw/rtl/linear_probe_key_root_cache.sv @@
// Open-addressed key/version to root cache with linear probing. One request
// transaction gives one response transaction. The slot array sits in one
// synchronous memory with a registered read; each probe step past the home
// slot goes through a read state and then a compare state. A lookup passes
// the accept, read, compare and done states, and an update, refresh or
// invalidate also a write state for the write back; flush, key zero and
// unused operation codes are answered from the idle state. An update that
// walks a full table starts a new epoch. The response is registered from
// the compare or write state, and the done state holds while a stalled
// response is not drained. Emptiness is kept with a per-slot epoch tag
// against a global epoch counter, so a flush needs no pass over the slots;
// after the epoch counter wraps, a clearing pass over every slot runs during
// which no request is taken. After reset the same clearing pass runs once.
module linear_probe_key_root_cache (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lpkrc_pkg::req_type   req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lpkrc_pkg::rsp_type   rsp_data
);

   localparam int AW = $clog2(lpkrc_pkg::CAPACITY);
   localparam int EW = 8;
   localparam int CW = AW + 1;

   typedef struct packed {
      logic [EW-1:0]      epoch;
      logic [63:0]        key;
      logic [31:0]        version;
      logic signed [15:0] root;
      logic               unsure;
   } slot_type;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_READ  = 6'b000100,
      ST_CHECK = 6'b001000,
      ST_WRITE = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   slot_type mem [lpkrc_pkg::CAPACITY];
   slot_type rd_ff;

   state_type          state_ff, state_in;
   lpkrc_pkg::req_type req_ff;
   logic [AW-1:0]      home_ff, idx_ff, idx_in;
   logic [CW-1:0]      steps_ff, steps_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [EW-1:0]      epoch_ff, epoch_in;
   logic               reins_ff, reins_in;
   logic               rsp_valid_ff;
   lpkrc_pkg::rsp_type rsp_ff, rsp_in;
   logic               rsp_load;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   slot_type           wr_data;
   logic [AW-1:0]      home_in;
   logic               used, key_eq, write_slot;
   logic [CW-1:0]      steps_nx;
   logic [AW-1:0]      idx_nx;
   logic               rsp_free;
   lpkrc_pkg::rsp_type pend_ff;
   logic               pend_valid_ff;

   assign home_in   = AW'(req_data.key >> lpkrc_pkg::KEY_SHIFT);
   assign used      = (rd_ff.epoch == epoch_ff);
   assign key_eq    = (rd_ff.key == req_ff.key);
   assign idx_nx    = (idx_ff == AW'(lpkrc_pkg::CAPACITY - 1)) ? '0 : idx_ff + 1'b1;
   assign steps_nx  = steps_ff + 1'b1;
   assign write_slot = (req_ff.operation != lpkrc_pkg::OP_UPDATE) || !used
                       || (rd_ff.version != req_ff.version) || rd_ff.unsure;

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall) || pend_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[idx_in];
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      steps_in = steps_ff;
      count_in = count_ff;
      epoch_in = epoch_ff;
      reins_in = reins_ff;
      rsp_load = 1'b0;
      rsp_in   = '0;
      wr_en    = 1'b0;
      wr_addr  = idx_ff;
      wr_data  = '{epoch: epoch_ff, key: req_ff.key, version: req_ff.version,
                   root: (req_ff.operation == lpkrc_pkg::OP_INVALIDATE) ? '0
                         : req_ff.root_found,
                   unsure: (req_ff.operation == lpkrc_pkg::OP_INVALIDATE)};
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            // The item of a full-table update keeps its home slot.
            if (!(reins_ff && idx_ff == home_ff)) begin
               wr_data = '0;
               wr_data.epoch = epoch_ff - 1'b1;
            end
            idx_in  = idx_nx;
            if (idx_ff == AW'(lpkrc_pkg::CAPACITY - 1)) begin
               state_in = ST_IDLE;
               reins_in = 1'b0;
            end
         end
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               idx_in   = home_in;
               steps_in = '0;
               if (req_data.operation == lpkrc_pkg::OP_FLUSH) begin
                  count_in = '0;
                  epoch_in = epoch_ff + 1'b1;
                  rsp_load = 1'b1;
                  // Epoch about to reach the stale tag of cleared slots.
                  if (epoch_ff == {EW{1'b1}} - 1'b1) begin
                     state_in = ST_CLEAR;
                     idx_in   = '0;
                     epoch_in = '0;
                     epoch_in[0] = 1'b1;
                  end
               end else if (req_data.operation inside
                            {[lpkrc_pkg::OP_LOOKUP:lpkrc_pkg::OP_INVALIDATE]} &&
                            req_data.key != '0) begin
                  state_in = ST_READ;
               end else begin
                  rsp_load = 1'b1;
               end
               rsp_in.entry_count = 13'(count_in);
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!used || key_eq) begin
               if (req_ff.operation == lpkrc_pkg::OP_LOOKUP) begin
                  rsp_load = 1'b1;
                  state_in = ST_DONE;
                  if (used && rd_ff.version == req_ff.version && !rd_ff.unsure) begin
                     rsp_in.hit  = 1'b1;
                     rsp_in.root = rd_ff.root;
                  end
                  rsp_in.probes      = 13'(steps_ff);
                  rsp_in.entry_count = 13'(count_ff);
               end else begin
                  state_in = ST_WRITE;
               end
            end else if (steps_nx == CW'(lpkrc_pkg::CAPACITY)) begin
               steps_in = steps_nx;
               if (req_ff.operation == lpkrc_pkg::OP_LOOKUP) begin
                  rsp_load = 1'b1;
                  state_in = ST_DONE;
                  rsp_in.probes      = 13'(steps_nx);
                  rsp_in.entry_count = 13'(count_ff);
               end else begin
                  // Table full: new epoch empties it, item goes to its home.
                  rsp_load = 1'b1;
                  state_in = ST_DONE;
                  wr_en    = 1'b1;
                  wr_addr  = home_ff;
                  wr_data.epoch = epoch_ff + 1'b1;
                  epoch_in = epoch_ff + 1'b1;
                  count_in = CW'(1);
                  rsp_in.probes      = 13'(steps_nx);
                  rsp_in.flushed     = 1'b1;
                  rsp_in.entry_count = 13'(count_in);
                  if (epoch_ff == {EW{1'b1}} - 1'b1) begin
                     state_in = ST_CLEAR;
                     idx_in   = '0;
                     epoch_in = '0;
                     epoch_in[0] = 1'b1;
                     wr_data.epoch = epoch_in;
                     reins_in = 1'b1;
                  end
               end
            end else begin
               steps_in = steps_nx;
               idx_in   = idx_nx;
               state_in = ST_CHECK;
            end
            if (state_in == ST_CHECK) begin
               state_in = ST_READ;
            end
         end
         ST_WRITE: begin
            if (write_slot) begin
               wr_en = 1'b1;
               if (!used) begin
                  count_in = count_ff + 1'b1;
               end
            end
            rsp_load = 1'b1;
            rsp_in.probes      = 13'(steps_ff);
            rsp_in.entry_count = 13'(count_in);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response register loads only when it is empty or being drained; a busy
   // probe holds in ST_DONE if the previous response is still stalled.
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         idx_ff        <= '0;
         steps_ff      <= '0;
         count_ff      <= '0;
         epoch_ff      <= EW'(1);
         reins_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         steps_ff <= steps_in;
         count_ff <= count_in;
         epoch_ff <= epoch_in;
         reins_ff <= reins_in;
         if (rsp_load && !rsp_free) begin
            pend_valid_ff <= 1'b1;
         end else if (pend_valid_ff && rsp_free) begin
            pend_valid_ff <= 1'b0;
         end
         if (rsp_free) begin
            rsp_valid_ff <= rsp_load || pend_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid && !req_stall) begin
         req_ff  <= req_data;
         home_ff <= home_in;
      end
      if (rsp_load) begin
         pend_ff <= rsp_in;
      end
      if (rsp_free) begin
         rsp_ff <= rsp_load ? rsp_in : pend_ff;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(lpkrc_pkg::CAPACITY))
      else $error("entry count exceeds capacity");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("request taken while busy");
   a_one_pending: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> rsp_valid_ff)
      else $error("pending response without output response");
   a_clear_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> wr_en)
      else $error("clearing pass skipped a slot");

endmodule
